// ===== hw/rtl/i2ra_pkg.sv =====
// Shared constants, types and helper functions for the integer to radix ASCII converter.
`default_nettype none

package i2ra_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH + 1);
   localparam int INDEX_WIDTH = $clog2(VALUE_WIDTH);
   localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;

   // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
   localparam logic [VALUE_WIDTH-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                     RECIP_SHIFT = 35;
   localparam int                     QUOT_WIDTH  = PROD_WIDTH - RECIP_SHIFT;

   localparam logic [1:0] RADIX_BIN = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_DEC = 2'd2;
   localparam logic [1:0] RADIX_HEX = 2'd3;

   localparam logic [7:0] ASCII_ZERO   = 8'd48;
   localparam logic [7:0] ASCII_LETTER = 8'd55;
   localparam logic [7:0] ASCII_B      = 8'd98;
   localparam logic [7:0] ASCII_O      = 8'd111;
   localparam logic [7:0] ASCII_X      = 8'd120;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_STEP,
      ST_PFX0,
      ST_PFX1,
      ST_POP
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic step;
      logic pfx0;
      logic pfx1;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic is_decimal;
      logic has_prefix;
      logic div_done;
      logic stack_one;
      logic out_free;
   } status_type;

   function automatic logic [7:0] prefix_letter(input logic [1:0] sel);
      logic [7:0] c;
      case (sel)
         RADIX_BIN: c = ASCII_B;
         RADIX_OCT: c = ASCII_O;
         RADIX_HEX: c = ASCII_X;
         default:   c = ASCII_ZERO;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d <= 4'd9) begin
         c = ASCII_ZERO + {4'd0, d};
      end else begin
         c = ASCII_LETTER + {4'd0, d};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2ra_datapath.sv =====
// Datapath: magnitude register, digit extraction, digit stack and output register.
`default_nettype none

module i2ra_datapath (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire logic [i2ra_pkg::VALUE_WIDTH-1:0]  req_value,
   input  wire logic [1:0]                        req_radix_select,
   input  wire i2ra_pkg::cmd_type                 cmd,
   output i2ra_pkg::status_type                   status,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic [7:0]                             rsp_ascii_char,
   output logic                                   rsp_last
);
   import i2ra_pkg::*;

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [1:0]             sel_ff;
   logic [PROD_WIDTH-1:0]  prod_ff;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [3:0]             stack_ff [VALUE_WIDTH];
   logic                   valid_ff, valid_in;
   logic [7:0]             char_ff, char_in;
   logic                   last_ff, last_in;

   logic [VALUE_WIDTH-1:0] load_mag;
   logic [VALUE_WIDTH-1:0] next_mag;
   logic [3:0]             digit;
   logic [QUOT_WIDTH-1:0]  quot;
   logic [VALUE_WIDTH-1:0] quot_ext;
   logic [VALUE_WIDTH-1:0] tens;
   logic [VALUE_WIDTH-1:0] rem;
   logic [COUNT_WIDTH-1:0] count_dec;
   logic                   out_free;
   logic                   push_ok;

   assign load_mag = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;

   assign quot     = prod_ff[PROD_WIDTH-1:RECIP_SHIFT];
   assign quot_ext = {{(VALUE_WIDTH-QUOT_WIDTH){1'b0}}, quot};
   assign tens     = (quot_ext << 3) + (quot_ext << 1);
   assign rem      = mag_ff - tens;

   always_comb begin
      case (sel_ff)
         RADIX_BIN: begin
            digit    = {3'd0, mag_ff[0]};
            next_mag = mag_ff >> 1;
         end
         RADIX_OCT: begin
            digit    = {1'b0, mag_ff[2:0]};
            next_mag = mag_ff >> 3;
         end
         RADIX_HEX: begin
            digit    = mag_ff[3:0];
            next_mag = mag_ff >> 4;
         end
         default: begin
            digit    = rem[3:0];
            next_mag = quot_ext;
         end
      endcase
   end

   assign count_dec = count_ff - 1'b1;
   assign out_free  = !valid_ff || rsp_ready;
   assign push_ok   = count_ff < COUNT_WIDTH'(VALUE_WIDTH);

   always_comb begin
      mag_in   = mag_ff;
      count_in = count_ff;
      if (cmd.load) begin
         mag_in   = load_mag;
         count_in = '0;
      end else if (cmd.step) begin
         mag_in = next_mag;
         if (push_ok) begin
            count_in = count_ff + 1'b1;
         end
      end else if (cmd.pop) begin
         count_in = count_dec;
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      char_in  = char_ff;
      last_in  = last_ff;
      if (cmd.pfx0) begin
         valid_in = 1'b1;
         char_in  = ASCII_ZERO;
         last_in  = 1'b0;
      end else if (cmd.pfx1) begin
         valid_in = 1'b1;
         char_in  = prefix_letter(sel_ff);
         last_in  = 1'b0;
      end else if (cmd.pop) begin
         valid_in = 1'b1;
         char_in  = digit_char(stack_ff[count_dec[INDEX_WIDTH-1:0]]);
         last_in  = (count_ff == COUNT_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (cmd.load) begin
         sel_ff <= req_radix_select;
      end
      if (cmd.mul) begin
         prod_ff <= mag_ff * RECIP_TEN;
      end
      if (cmd.step && push_ok) begin
         stack_ff[count_ff[INDEX_WIDTH-1:0]] <= digit;
      end
   end

   assign status.is_decimal = (sel_ff == RADIX_DEC);
   assign status.has_prefix = (sel_ff != RADIX_DEC);
   assign status.div_done   = (next_mag == '0);
   assign status.stack_one  = (count_ff == COUNT_WIDTH'(1));
   assign status.out_free   = out_free;

   assign rsp_valid      = valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last       = last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(VALUE_WIDTH))
      else $error("digit count beyond stack depth");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.pfx0 || cmd.pfx1 || cmd.pop) |-> out_free)
      else $error("character emitted over an untaken transaction");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (count_ff != '0))
      else $error("pop from empty digit stack");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (count_ff == '0))
      else $error("digit count not cleared on new transaction");

endmodule

`default_nettype wire

// ===== hw/rtl/i2ra_ctrl.sv =====
// Controller state machine sequencing division, prefix and digit pops.
`default_nettype none

module i2ra_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire i2ra_pkg::status_type  status,
   output i2ra_pkg::cmd_type          cmd
);
   import i2ra_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (!status.div_done) begin
               state_in = status.is_decimal ? ST_MUL : ST_STEP;
            end else begin
               state_in = status.has_prefix ? ST_PFX0 : ST_POP;
            end
         end
         ST_PFX0: begin
            if (status.out_free) begin
               state_in = ST_PFX1;
            end
         end
         ST_PFX1: begin
            if (status.out_free) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (status.out_free && status.stack_one) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
         end
         ST_PFX0: begin
            cmd.pfx0 = status.out_free;
         end
         ST_PFX1: begin
            cmd.pfx1 = status.out_free;
         end
         ST_POP: begin
            cmd.pop = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/integer_to_radix_ascii.sv =====
// Top level: signed integer to ASCII string of its magnitude (no sign character) in base 2, 8, 10 or 16.
//
//  channel  | ports                                 | direction
//  ---------+---------------------------------------+----------
//  request  | req_valid/ready, value, radix_select  | in
//  response | rsp_valid/ready, ascii_char, last     | out
//
// One request transaction yields a run of response transactions, the last flagged.
// Digits: bases 2, 8, 16 shift one digit per ST_STEP; base 10 alternates ST_MUL (multiply
// by reciprocal) and ST_STEP (subtract). Then characters leave at one per cycle while
// the output register is free.
// Synchronous active-high reset clears the controller, digit count and output valid.
// Response stalls hold the controller; a new request is taken while the last
// character still waits in the output register.
`default_nettype none

module integer_to_radix_ascii (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  wire logic [i2ra_pkg::VALUE_WIDTH-1:0]  req_value,
   input  wire logic [1:0]                        req_radix_select,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic [7:0]                             rsp_ascii_char,
   output logic                                   rsp_last
);
   import i2ra_pkg::*;

   cmd_type    cmd;
   status_type status;

   i2ra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   i2ra_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .req_radix_select (req_radix_select),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ascii_char   (rsp_ascii_char),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for integer_to_radix_ascii: directed, random and backpressure runs checked per character.
`timescale 1ns / 1ps

module tb;
   import i2ra_pkg::*;

   typedef struct packed {
      logic [7:0] ascii_char;
      logic       last;
   } ascii_rec_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [VALUE_WIDTH-1:0] req_value        = '0;
   logic [1:0]             req_radix_select = RADIX_BIN;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [7:0]             rsp_ascii_char;
   logic                   rsp_last;

   ascii_rec_type pending_chars[$];
   int            fail_count    = 0;
   bit            idle_en       = 1'b1;
   int            rsp_hold_left = 0;

   integer_to_radix_ascii u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_radix_select (req_radix_select),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ascii_char   (rsp_ascii_char),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 500000);
      $display("tb: failure");
      $finish;
   end

   // expected character run for one conversion: prefix, then digits MSB first
   function automatic void predict_ascii_run(input logic [VALUE_WIDTH-1:0] value,
                                             input logic [1:0] sel);
      logic [VALUE_WIDTH-1:0] mag;
      logic [VALUE_WIDTH-1:0] base;
      logic [7:0]             letter;
      logic [3:0]             digits[$];
      ascii_rec_type          rec;
      mag    = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      base   = 10;
      letter = ASCII_ZERO;
      case (sel)
         RADIX_BIN: begin
            base   = 2;
            letter = ASCII_B;
         end
         RADIX_OCT: begin
            base   = 8;
            letter = ASCII_O;
         end
         RADIX_HEX: begin
            base   = 16;
            letter = ASCII_X;
         end
         default: ;
      endcase
      do begin
         digits.push_front(4'(mag % base));
         mag = mag / base;
      end while (mag != 0);
      if (sel != RADIX_DEC) begin
         pending_chars.push_back('{ascii_char: ASCII_ZERO, last: 1'b0});
         pending_chars.push_back('{ascii_char: letter, last: 1'b0});
      end
      foreach (digits[i]) begin
         rec.ascii_char = (digits[i] <= 4'd9) ? ASCII_ZERO + digits[i]
                                               : ASCII_LETTER + digits[i];
         rec.last       = (i == digits.size() - 1);
         pending_chars.push_back(rec);
      end
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] random_value();
      logic [VALUE_WIDTH-1:0] v;
      case ($urandom_range(4))
         0: v = $urandom_range(0, 40);
         1: v = -$urandom_range(1, 40);
         2: v = (32'd1 << $urandom_range(31)) + $urandom_range(0, 2) - 32'd1;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_conversion(input logic [VALUE_WIDTH-1:0] value,
                                  input logic [1:0] sel);
      @(negedge clock);
      if (idle_en) begin
         while ($urandom_range(99) < 8) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_value        <= value;
      req_radix_select <= sel;
      do @(posedge clock); while (!req_ready);
      predict_ascii_run(value, sel);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // receiver: random stalls, or a counted hold-off when requested
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ready <= !idle_en || ($urandom_range(99) >= 8);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      ascii_rec_type exp_rec;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected transaction: ascii_char=%h last=%b", rsp_ascii_char, rsp_last);
            fail_count++;
         end else begin
            exp_rec = pending_chars.pop_front();
            if (rsp_ascii_char !== exp_rec.ascii_char) begin
               $error("ascii_char: expected %h, got %h", exp_rec.ascii_char, rsp_ascii_char);
               fail_count++;
            end
            if (rsp_last !== exp_rec.last) begin
               $error("last: expected %b, got %b", exp_rec.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   task automatic test_directed();
      logic [VALUE_WIDTH-1:0] corners[3];
      corners = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
      foreach (corners[i]) begin
         send_conversion(corners[i], RADIX_BIN);
         send_conversion(corners[i], RADIX_OCT);
         send_conversion(corners[i], RADIX_DEC);
         send_conversion(corners[i], RADIX_HEX);
      end
      send_conversion(32'h7ABC_DEF0, RADIX_HEX);
      send_conversion(-32'sd1, RADIX_DEC);
      send_conversion(32'd9, RADIX_DEC);
      send_conversion(32'd10, RADIX_DEC);
      send_conversion(32'd1, RADIX_BIN);
      send_conversion(32'd2, RADIX_BIN);
      send_conversion(32'd7, RADIX_OCT);
      send_conversion(32'd8, RADIX_OCT);
      send_conversion(32'd15, RADIX_HEX);
      send_conversion(32'd16, RADIX_HEX);
      send_conversion(32'd1234567890, RADIX_DEC);
      send_conversion(-32'sd1234567890, RADIX_DEC);
      wait_drained();
   endtask

   task automatic test_random();
      repeat (300) send_conversion(random_value(), 2'($urandom_range(3)));
      wait_drained();
   endtask

   task automatic test_back_to_back();
      idle_en = 1'b0;
      repeat (40) send_conversion(random_value(), 2'($urandom_range(3)));
      wait_drained();
      idle_en = 1'b1;
   endtask

   // long receiver hold-off while requests keep coming, so the input stalls
   task automatic test_output_stall();
      idle_en       = 1'b0;
      rsp_hold_left = 400;
      repeat (20) send_conversion(random_value(), 2'($urandom_range(3)));
      wait_drained();
      idle_en = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      test_back_to_back();
      test_output_stall();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
